>>> rtl/hptff_pkg.sv
// Shared types, codes and constants for the hashed page table fault fill block.
// No dependencies; every other file imports this package.
package hptff_pkg;

   // Default sizes handed to the top level parameters
   localparam int unsigned PARTITIONS_DEF  = 16;
   localparam int unsigned GROUPS_DEF      = 1024;
   localparam int unsigned WAYS_DEF        = 8;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Fixed field widths
   localparam int GRP_W  = 10;
   localparam int SLOT_W = 3;
   localparam int PART_W = 4;

   // Group wrap: reciprocal precision for group modulo table size
   localparam int RECIP_SHIFT = 20;

   // Fault status word: page fault flag position
   localparam int FAULT_BIT = 30;

   // Group mask register reset value
   localparam logic [GRP_W-1:0] GROUP_MASK_RST = 10'h3ff;

   typedef enum logic {
      OP_DEFINE = 1'b0,
      OP_FAULT  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STS_INSERTED     = 3'd0,
      STS_DEFINED      = 3'd1,
      STS_NOT_FAULT    = 3'd2,
      STS_OUT_OF_RANGE = 3'd3,
      STS_GROUP_FULL   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_INDEX,
      BK_UPDATE
   } back_state_type;

   // Request payload
   typedef struct packed {
      logic              op;
      logic [PART_W-1:0] partition;
      logic [31:0]       address;
      logic [31:0]       region_size;
      logic [31:0]       fault_status;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [2:0]        status;
      logic [GRP_W-1:0]  group;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       tag_word;
      logic [31:0]       frame_word;
   } rsp_type;

   // Classified job passed from the front end to the table update engine
   typedef struct packed {
      status_type       status;
      logic [GRP_W-1:0] group;
      logic [31:0]      tag_word;
      logic [31:0]      frame_word;
   } job_type;

endpackage

>>> rtl/hptff_front.sv
// Front end: accepts requests, keeps the partition table, classifies faults
// and builds the page table entry. Depends on hptff_pkg.
module hptff_front
   import hptff_pkg::*;
#(
   parameter int unsigned PARTITIONS = PARTITIONS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clr_busy,
   input  logic [GRP_W-1:0] group_mask,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output job_type          push_data
);

   localparam int PART_AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

   // Partition table: {base, size} per partition, valid bits cleared by reset
   logic [63:0]           part_mem [PARTITIONS];
   logic [PARTITIONS-1:0] part_vld_ff, part_vld_in;

   logic               accept;
   logic               known;
   logic [PART_AW-1:0] part_idx;

   logic        s1_vld_ff, s1_vld_in;
   req_type     s1_req_ff;
   logic [63:0] rd_entry_ff;
   logic        rd_vld_ff;

   logic [31:0] base;
   logic [31:0] size;
   logic [15:0] hash;
   logic [19:0] ppn;

   // Handshake: one request held in the classify stage
   assign req_ready = (!s1_vld_ff || push_ready) && !clr_busy;
   assign accept    = req_valid && req_ready;
   assign known     = 32'(req_data.partition) < 32'(PARTITIONS);
   assign part_idx  = PART_AW'(req_data.partition);

   // Partition valid bits
   always_comb begin
      part_vld_in = part_vld_ff;
      if (accept && req_data.op == OP_DEFINE && known) begin
         part_vld_in[part_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_vld_ff <= '0;
      end else begin
         part_vld_ff <= part_vld_in;
      end
   end

   // Partition table write on define, registered read on fault
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
         if (req_data.op == OP_DEFINE) begin
            if (known) begin
               part_mem[part_idx] <= {req_data.address, req_data.region_size};
            end
         end else begin
            rd_entry_ff <= part_mem[part_idx];
            rd_vld_ff   <= known && part_vld_ff[part_idx];
         end
      end
   end

   // Classify stage occupancy
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (push_ready) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   // Classification, hash and entry build
   assign base = rd_vld_ff ? rd_entry_ff[63:32] : '0;
   assign size = rd_vld_ff ? rd_entry_ff[31:0]  : '0;
   assign hash = {12'b0, s1_req_ff.partition} ^ s1_req_ff.address[27:12];
   assign ppn  = base[31:12] + s1_req_ff.address[31:12];

   always_comb begin
      push_data = '0;
      if (s1_req_ff.op == OP_DEFINE) begin
         push_data.status = STS_DEFINED;
      end else if (!s1_req_ff.fault_status[FAULT_BIT]) begin
         push_data.status = STS_NOT_FAULT;
      end else if (s1_req_ff.address >= size) begin
         push_data.status = STS_OUT_OF_RANGE;
      end else begin
         push_data.status     = STS_INSERTED;
         push_data.group      = hash[GRP_W-1:0] & group_mask;
         // valid, partition id at bit 7, page index from address bits 27..22
         push_data.tag_word   = {1'b1, 20'b0, s1_req_ff.partition, 1'b0,
                                 s1_req_ff.address[27:22]};
         // physical page, R and C set, read-write protection
         push_data.frame_word = {ppn, 3'b000, 1'b1, 1'b1, 5'b00000, 2'b10};
      end
   end

   assign push_valid = s1_vld_ff;

endmodule

>>> rtl/hptff_queue.sv
// Small job queue between the front end and the table update engine.
// Depends on hptff_pkg for the job type.
module hptff_queue
   import hptff_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         q_mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push;
   logic            pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = q_mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/hptff_back.sv
// Table update engine: clears the slot valid memory after reset, searches a
// group for a free slot, marks it and drives the response register. Uses hptff_pkg.
module hptff_back
   import hptff_pkg::*;
#(
   parameter int unsigned GROUPS = GROUPS_DEF,
   parameter int unsigned WAYS   = WAYS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   output logic    clr_busy,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  job_type pop_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int          ROW_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int          WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned RECIP  = (32'd1 << RECIP_SHIFT) / GROUPS;
   localparam int          PROD_W = GRP_W + RECIP_SHIFT + 1;
   localparam int          REM_W  = GRP_W + 18;

   // One row of slot valid bits per group
   logic [WAYS-1:0] vmem [GROUPS];

   back_state_type  state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic            rsp_vld_ff, rsp_vld_in;
   rsp_type         rsp_ff;
   job_type         job_ff;
   logic [GRP_W-1:0] quot_ff;
   logic [ROW_W-1:0] row_idx_ff;
   logic [WAYS-1:0] row_rd_ff;

   logic             out_free;
   logic             is_fill;
   logic             pop;
   logic             clr_last;
   logic [PROD_W-1:0] prod;
   logic [REM_W-1:0] rem;
   logic [REM_W-1:0] rem_fix;
   logic [ROW_W-1:0] row_idx;
   logic             found;
   logic [WAY_W-1:0] way_idx;
   logic [WAYS-1:0]  set_mask;
   logic             mem_we;
   logic [ROW_W-1:0] mem_waddr;
   logic [WAYS-1:0]  mem_wdata;
   logic             load_out;
   rsp_type          rsp_next;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign is_fill  = pop_data.status == STS_INSERTED;
   assign pop      = pop_valid && pop_ready;
   assign clr_last = clr_ff == ROW_W'(GROUPS - 1);

   // Group modulo table size: reciprocal quotient, then one correction
   assign prod    = PROD_W'(pop_data.group) * PROD_W'(RECIP);
   assign rem     = REM_W'(job_ff.group) - REM_W'(quot_ff) * REM_W'(GROUPS);
   assign rem_fix = (rem >= REM_W'(GROUPS)) ? rem - REM_W'(GROUPS) : rem;
   assign row_idx = ROW_W'(rem_fix);

   // First free slot in the fetched row
   always_comb begin
      found    = 1'b0;
      way_idx  = '0;
      set_mask = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!row_rd_ff[i]) begin
            found   = 1'b1;
            way_idx = WAY_W'(i);
         end
      end
      set_mask[way_idx] = 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop && is_fill) begin
               state_in = BK_INDEX;
            end
         end
         BK_INDEX: begin
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      clr_busy  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = row_idx_ff;
      mem_wdata = row_rd_ff | set_mask;
      load_out  = 1'b0;
      rsp_next  = '0;
      case (state_ff)
         BK_CLEAR: begin
            clr_busy  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         BK_IDLE: begin
            pop_ready = is_fill || out_free;
            if (pop && !is_fill) begin
               load_out            = 1'b1;
               rsp_next.status     = pop_data.status;
               rsp_next.group      = pop_data.group;
               rsp_next.tag_word   = pop_data.tag_word;
               rsp_next.frame_word = pop_data.frame_word;
            end
         end
         BK_INDEX: begin
         end
         BK_UPDATE: begin
            if (out_free) begin
               load_out       = 1'b1;
               rsp_next.group = job_ff.group;
               if (found) begin
                  mem_we              = 1'b1;
                  rsp_next.status     = STS_INSERTED;
                  rsp_next.slot       = SLOT_W'(way_idx);
                  rsp_next.tag_word   = job_ff.tag_word;
                  rsp_next.frame_word = job_ff.frame_word;
               end else begin
                  rsp_next.status = STS_GROUP_FULL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_comb begin
      clr_in     = (state_ff == BK_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      rsp_vld_in = rsp_vld_ff;
      if (load_out) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Job capture and response register
   always_ff @(posedge clock) begin
      if (pop && is_fill) begin
         job_ff  <= pop_data;
         quot_ff <= prod[RECIP_SHIFT +: GRP_W];
      end
      if (load_out) begin
         rsp_ff <= rsp_next;
      end
   end

   // Slot valid memory: one row read, one row written
   always_ff @(posedge clock) begin
      if (state_ff == BK_INDEX) begin
         row_idx_ff <= row_idx;
         row_rd_ff  <= vmem[row_idx];
      end
      if (mem_we) begin
         vmem[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/hashed_page_table_fault_fill.sv
// Hashed page table fault fill, top level: group mask register and the
// front end, job queue and table update engine. Uses hptff_pkg.
//
// Requests arrive on req_valid/req_ready with req_data; one response per
// request leaves on rsp_valid/rsp_ready with rsp_data, in request order.
// A define transfer records a partition's base and size; a fault transfer
// is checked and, when it qualifies, fills the first free slot of its group.
// csr_wr_en writes the 10-bit group mask at once; write it only while idle.
// After reset the slot valid memory is swept clear, one group per cycle,
// over all GROUPS (1024 by default); req_ready stays low during the sweep.
// The engine takes a fill through index, row read and write-back (one
// memory port) before its next job; other items pass at one per cycle
// while the engine is idle and rsp_ready is high. A stalled receiver holds
// the response register; up to two jobs then wait in the queue and one in
// the front end before req_ready drops.
module hashed_page_table_fault_fill
   import hptff_pkg::*;
#(
   parameter int unsigned PARTITIONS  = PARTITIONS_DEF,
   parameter int unsigned GROUPS      = GROUPS_DEF,
   parameter int unsigned WAYS        = WAYS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [GRP_W-1:0] csr_wr_data
);

   logic [GRP_W-1:0] group_mask_ff, group_mask_in;
   logic             clr_busy;
   logic             push_valid;
   logic             push_ready;
   job_type          push_data;
   logic             pop_valid;
   logic             pop_ready;
   job_type          pop_data;

   // Group mask register
   assign group_mask_in = csr_wr_en ? csr_wr_data : group_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_mask_ff <= GROUP_MASK_RST;
      end else begin
         group_mask_ff <= group_mask_in;
      end
   end

   hptff_front #(
      .PARTITIONS (PARTITIONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clr_busy   (clr_busy),
      .group_mask (group_mask_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   hptff_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hptff_back #(
      .GROUPS (GROUPS),
      .WAYS   (WAYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clr_busy  (clr_busy),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for hashed_page_table_fault_fill: directed and random
// partition defines and page faults, checked against an in-bench table model.
// Depends on rtl/hptff_pkg.sv and rtl/hashed_page_table_fault_fill.sv.
module tb_top;
   import hptff_pkg::*;

   localparam int          CLK_HALF    = 6;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          HOLD_CYCLES = 300;
   localparam int          TAIL_CYCLES = 8;
   localparam logic [31:0] TAG_VALID   = 32'h8000_0000;
   localparam logic [31:0] FLAG_REF    = 32'h0000_0100;
   localparam logic [31:0] FLAG_CHG    = 32'h0000_0080;
   localparam logic [31:0] PROT_RW     = 32'h0000_0002;
   localparam logic [31:0] FAULT_FLAG  = 32'h1 << FAULT_BIT;
   localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
   localparam logic [GRP_W-1:0] MASK_MIN = '0;
   localparam logic [GRP_W-1:0] MASK_MAX = '1;

   // DUT ports; the inputs are known from time zero
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [GRP_W-1:0] csr_wr_data = '0;

   // Table model state
   logic [31:0]      part_base_tbl [PARTITIONS_DEF];
   logic [31:0]      part_size_tbl [PARTITIONS_DEF];
   int unsigned      slots_taken   [GROUPS_DEF];
   logic [GRP_W-1:0] mask_shadow = GROUP_MASK_RST;

   rsp_type     fill_results_due [$];
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_requests  = 0;
   int          hold_granted   = 0;
   int          hold_left      = 0;
   int          cycle_count    = 0;
   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          mask_writes    = 0;
   int          status_count [8];

   hashed_page_table_fault_fill u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("hashed_page_table_fault_fill verification failed");
         $finish;
      end
   end

   // Expected response for one accepted request; updates the table model
   function automatic rsp_type compute_fill_result(input req_type item);
      rsp_type     res;
      logic [31:0] page;
      logic [31:0] phys;
      logic [GRP_W-1:0] grp;
      int unsigned row;
      res = '0;
      if (item.op == OP_DEFINE) begin
         part_base_tbl[item.partition] = item.address;
         part_size_tbl[item.partition] = item.region_size;
         res.status = STS_DEFINED;
         return res;
      end
      if (!item.fault_status[FAULT_BIT]) begin
         res.status = STS_NOT_FAULT;
         return res;
      end
      if (item.address >= part_size_tbl[item.partition]) begin
         res.status = STS_OUT_OF_RANGE;
         return res;
      end
      page = {item.address[31:12], 12'h000};
      grp  = (GRP_W'(item.partition) ^ page[21:12]) & mask_shadow;
      row  = grp % GROUPS_DEF;
      res.group = grp;
      if (slots_taken[row] >= WAYS_DEF) begin
         res.status = STS_GROUP_FULL;
         return res;
      end
      phys = part_base_tbl[item.partition] + page;
      res.status     = STS_INSERTED;
      res.slot       = SLOT_W'(slots_taken[row]);
      res.tag_word   = TAG_VALID | (32'(item.partition) << 7) | 32'(page[27:22]);
      res.frame_word = {phys[31:12], 12'h000} | FLAG_REF | FLAG_CHG | PROT_RW;
      slots_taken[row]++;
      return res;
   endfunction

   function automatic req_type make_req(input op_type op, input logic [PART_W-1:0] part,
                                        input logic [31:0] addr, input logic [31:0] size,
                                        input logic [31:0] fstat);
      req_type item;
      item.op           = op;
      item.partition    = part;
      item.address      = addr;
      item.region_size  = size;
      item.fault_status = fstat;
      return item;
   endfunction

   // Mostly in-range faults on live partitions, the rest defines and misses
   function automatic req_type gen_traffic_item();
      req_type          item;
      int               pick;
      logic [PART_W-1:0] part;
      logic [63:0]      span;
      pick = $urandom_range(99);
      part = PART_W'($urandom_range(PARTITIONS_DEF - 1));
      item = make_req(OP_FAULT, part, $urandom, $urandom, $urandom | FAULT_FLAG);
      if (pick < 8) begin
         item.op = OP_DEFINE;
         case ($urandom_range(3))
            0: item.region_size = ALL_ONES;
            1: item.region_size = $urandom;
            2: item.region_size = $urandom_range(32'h0010_0000, 1);
            default: item.region_size = '0;
         endcase
      end else if (pick < 14) begin
         item.fault_status = $urandom & ~FAULT_FLAG;
      end else if (pick < 20) begin
         span = 64'h1_0000_0000 - {32'b0, part_size_tbl[part]};
         item.address = part_size_tbl[part] + 32'({32'b0, 32'($urandom)} % span);
      end else begin
         for (int k = 0; k < PARTITIONS_DEF && part_size_tbl[part] == 0; k++)
            part = part + 1'b1;
         item.partition = part;
         if (part_size_tbl[part] != 0)
            item.address = 32'({32'b0, 32'($urandom)} % {32'b0, part_size_tbl[part]});
      end
      return item;
   endfunction

   // One request transfer; valid is left high after acceptance
   task automatic send_req(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      fill_results_due.push_back(compute_fill_result(item));
      items_sent++;
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fill_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_group_mask(input logic [GRP_W-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mask_shadow = value;
      mask_writes++;
   endtask

   // Receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_granted != hold_requests) begin
         hold_granted = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string field, input logic [31:0] due_val,
                              input logic [31:0] got_val);
      if (due_val !== got_val) begin
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                  $time, field, due_val, got_val);
         mismatch_count++;
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         status_count[rsp_data.status]++;
         if (fill_results_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual 0x%h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            due = fill_results_due.pop_front();
            check_field("status",     32'(due.status),  32'(rsp_data.status));
            check_field("group",      32'(due.group),   32'(rsp_data.group));
            check_field("slot",       32'(due.slot),    32'(rsp_data.slot));
            check_field("tag_word",   due.tag_word,     rsp_data.tag_word);
            check_field("frame_word", due.frame_word,   rsp_data.frame_word);
         end
      end
   end

   // Every status code, field extremes, address wrap and a full group
   task automatic test_directed_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // no partition defined yet: size zero
      send_req(make_req(OP_FAULT, 4'd0, 32'h0000_1000, ALL_ONES, ALL_ONES));
      send_req(make_req(OP_FAULT, 4'd3, 32'h0000_0000, '0, ALL_ONES & ~FAULT_FLAG));
      send_req(make_req(OP_DEFINE, 4'd0, 32'h0000_0000, ALL_ONES, '0));
      send_req(make_req(OP_DEFINE, 4'd15, 32'hffff_f000, 32'h0001_0000, ALL_ONES));
      send_req(make_req(OP_DEFINE, 4'd5, 32'h1234_5000, 32'h0000_1000, '0));
      send_req(make_req(OP_FAULT, 4'd0, 32'h0000_0000, '0, FAULT_FLAG));
      send_req(make_req(OP_FAULT, 4'd0, 32'hffff_fffe, ALL_ONES, ALL_ONES));
      // address equal to the size is out of range
      send_req(make_req(OP_FAULT, 4'd0, ALL_ONES, '0, FAULT_FLAG));
      // physical page wraps past 2^32
      send_req(make_req(OP_FAULT, 4'd15, 32'h0000_ffff, '0, FAULT_FLAG));
      send_req(make_req(OP_FAULT, 4'd5, 32'h0000_0fff, '0, FAULT_FLAG));
      send_req(make_req(OP_FAULT, 4'd5, 32'h0000_1000, '0, FAULT_FLAG));
      send_req(make_req(OP_FAULT, 4'd0, 32'h0000_0000, '0, '0));
      // nine faults into one group: eight fills, then group full
      for (int i = 0; i < WAYS_DEF + 1; i++)
         send_req(make_req(OP_FAULT, 4'd0, 32'h0004_2000 | (32'(i) << 22), '0, FAULT_FLAG));
      send_req(make_req(OP_DEFINE, 4'd15, ALL_ONES, '0, '0));
      send_req(make_req(OP_FAULT, 4'd15, 32'h0000_0000, '0, FAULT_FLAG));
      drain_responses();
   endtask

   // Live partitions first, then mixed traffic under one mask and idle pattern
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct, input logic [GRP_W-1:0] mask);
      write_group_mask(mask);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int p = 0; p < PARTITIONS_DEF; p++)
         send_req(make_req(OP_DEFINE, PART_W'(p), $urandom,
                           ($urandom_range(1)) ? ALL_ONES : $urandom | 32'h8000_0000,
                           $urandom));
      for (int i = 0; i < count; i++)
         send_req(gen_traffic_item());
      drain_responses();
   endtask

   // Mask zero funnels every fault into group zero until it is full
   task automatic test_mask_extremes();
      write_group_mask(MASK_MIN);
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      for (int i = 0; i < 24; i++)
         send_req(gen_traffic_item());
      drain_responses();
   endtask

   // Long receiver hold-off while requests keep coming: the block must back up
   task automatic test_output_holdoff();
      write_group_mask(MASK_MAX);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      for (int i = 0; i < 40; i++)
         send_req(gen_traffic_item());
      drain_responses();
   endtask

   initial begin
      for (int p = 0; p < PARTITIONS_DEF; p++) begin
         part_base_tbl[p] = '0;
         part_size_tbl[p] = '0;
      end
      for (int g = 0; g < GROUPS_DEF; g++)
         slots_taken[g] = 0;
      for (int s = 0; s < 8; s++)
         status_count[s] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_mask_extremes();
      test_random_traffic(280, 0, 0, MASK_MAX);
      test_random_traffic(280, 56, 0, 10'h2aa);
      test_random_traffic(280, 0, 56, 10'h155);
      test_random_traffic(280, 37, 37, 10'($urandom_range(1023)));
      test_output_holdoff();

      repeat (TAIL_CYCLES) @(posedge clock);
      mismatch_count += fill_results_due.size();
      $display("Covered %0d requests over %0d mask settings, idle/stall phases and a %0d-cycle",
               items_sent, mask_writes, HOLD_CYCLES);
      $display("hold-off: %0d inserted, %0d defined, %0d not fault, %0d out of range, %0d full",
               status_count[STS_INSERTED], status_count[STS_DEFINED],
               status_count[STS_NOT_FAULT], status_count[STS_OUT_OF_RANGE],
               status_count[STS_GROUP_FULL]);
      if (mismatch_count == 0) begin
         $display("hashed_page_table_fault_fill verification clean");
      end else begin
         $display("hashed_page_table_fault_fill verification failed");
      end
      $finish;
   end

endmodule
